// ===== rtl/core/xibe_pkg.sv =====
// ----------------------------------------------------------------------------
// x86 instruction byte encoder package
// Shared codes, slot layout, stage structs and small lookup functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xibe_pkg;

    // instruction kinds
    localparam logic [2:0] KIND_LEGACY = 3'd0;
    localparam logic [2:0] KIND_VEX    = 3'd1;
    localparam logic [2:0] KIND_3DNOW  = 3'd2;
    localparam logic [2:0] KIND_NOP    = 3'd3;

    // group 1 prefix codes
    localparam logic [1:0] GRP1_NONE  = 2'd0;
    localparam logic [1:0] GRP1_LOCK  = 2'd1;
    localparam logic [1:0] GRP1_REPNZ = 2'd2;
    localparam logic [1:0] GRP1_REPZ  = 2'd3;

    // segment override codes
    localparam logic [2:0] SEG_NONE = 3'd0;
    localparam logic [2:0] SEG_CS   = 3'd1;
    localparam logic [2:0] SEG_SS   = 3'd2;
    localparam logic [2:0] SEG_DS   = 3'd3;
    localparam logic [2:0] SEG_ES   = 3'd4;
    localparam logic [2:0] SEG_FS   = 3'd5;
    localparam logic [2:0] SEG_GS   = 3'd6;

    // argument size codes
    localparam logic [2:0] SIZE_BYTE  = 3'd1;
    localparam logic [2:0] SIZE_WORD  = 3'd2;
    localparam logic [2:0] SIZE_DWORD = 3'd3;
    localparam logic [2:0] SIZE_QWORD = 3'd4;

    // fixed byte values
    localparam logic [7:0] BYTE_OPSIZE  = 8'h66;
    localparam logic [7:0] BYTE_ADSIZE  = 8'h67;
    localparam logic [7:0] BYTE_REX     = 8'h40;
    localparam logic [7:0] BYTE_VEX2    = 8'hc5;
    localparam logic [7:0] BYTE_VEX3    = 8'hc4;
    localparam logic [7:0] BYTE_ESC     = 8'h0f;
    localparam logic [7:0] VEX_MAP_0F   = 8'h01;

    // slot layout of one instruction, in emit order
    localparam int NUM_SLOTS = 26;
    localparam int SLOT_PRE  = 0;    // five prefix slots (or VEX / 0F 0F / 66 run)
    localparam int SLOT_OP   = 5;    // three opcode slots
    localparam int SLOT_MS   = 8;    // ModRM, SIB
    localparam int SLOT_DISP = 10;   // eight displacement slots
    localparam int SLOT_IMM  = 18;   // eight immediate slots (or trailing opcode)
    localparam int NOP_MAX   = 14;   // longest run of 66 bytes

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  lock_rep;
        logic [2:0]  segment;
        logic [6:0]  prefix_bits;
        logic [12:0] vex_fields;
        logic [23:0] opcode;
        logic [1:0]  opcode_length;
        logic [17:0] modrm_sib;
        logic [63:0] displacement;
        logic [63:0] immediate;
        logic [5:0]  arg_sizes;
        logic [3:0]  nop_length;
    } item_t;

    typedef struct packed {
        logic [2:0]      kind;
        logic [4:0]      pre_mask;
        logic [4:0][7:0] pre_byte;
        logic            vex_long;
        logic [2:0][7:0] vex_byte;
        logic [2:0]      op_mask;
        logic [2:0][7:0] op_byte;
        logic [1:0]      ms_mask;
        logic [1:0][7:0] ms_byte;
        logic [7:0]      disp_mask;
        logic [63:0]     disp;
        logic [7:0]      imm_mask;
        logic [63:0]     imm;
        logic [3:0]      nop_len;
    } dec_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]      mask;
        logic [NUM_SLOTS-1:0][7:0] bytes;
    } slot_t;

    function automatic logic [7:0] grp1_byte(input logic [1:0] code);
        logic [7:0] b;
        case (code)
            GRP1_LOCK:  b = 8'hf0;
            GRP1_REPNZ: b = 8'hf2;
            GRP1_REPZ:  b = 8'hf3;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] seg_byte(input logic [2:0] code);
        logic [7:0] b;
        case (code)
            SEG_CS:  b = 8'h2e;
            SEG_SS:  b = 8'h36;
            SEG_DS:  b = 8'h3e;
            SEG_ES:  b = 8'h26;
            SEG_FS:  b = 8'h64;
            SEG_GS:  b = 8'h65;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] size_mask(input logic [2:0] code);
        logic [7:0] m;
        case (code)
            SIZE_BYTE:  m = 8'h01;
            SIZE_WORD:  m = 8'h03;
            SIZE_DWORD: m = 8'h0f;
            SIZE_QWORD: m = 8'hff;
            default:    m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/xibe_decode.sv =====
// ----------------------------------------------------------------------------
// x86 instruction byte encoder: decode stage
// Build prefix, VEX, opcode and argument bytes with their present bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xibe_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire xibe_pkg::item_t in_item,
    output logic                 in_stall,
    output logic                 dec_valid,
    output xibe_pkg::dec_t       dec,
    input  wire logic            dec_stall
);

    logic           valid_reg;
    logic           valid_next;
    xibe_pkg::dec_t dec_reg;
    xibe_pkg::dec_t dec_next;

    logic       w, r, x, b;
    logic [4:0] map;
    logic [3:0] vvvv;
    logic       l;
    logic [1:0] pp;
    logic       vex_short;

    assign in_stall = valid_reg && dec_stall;

    always_comb
    begin
        w    = in_item.prefix_bits[3];
        r    = in_item.prefix_bits[4];
        x    = in_item.prefix_bits[5];
        b    = in_item.prefix_bits[6];
        map  = in_item.vex_fields[4:0];
        vvvv = in_item.vex_fields[8:5];
        l    = in_item.vex_fields[9];
        pp   = in_item.vex_fields[11:10];
        vex_short = (!x && !b && !w && ({3'b000, map} == xibe_pkg::VEX_MAP_0F))
                    || in_item.vex_fields[12];

        dec_next.kind = in_item.kind;

        dec_next.pre_mask[0] = in_item.lock_rep != xibe_pkg::GRP1_NONE;
        dec_next.pre_byte[0] = xibe_pkg::grp1_byte(in_item.lock_rep);
        dec_next.pre_byte[1] = xibe_pkg::seg_byte(in_item.segment);
        dec_next.pre_mask[1] = dec_next.pre_byte[1] != 8'h00;
        dec_next.pre_mask[2] = in_item.prefix_bits[0];
        dec_next.pre_byte[2] = xibe_pkg::BYTE_OPSIZE;
        dec_next.pre_mask[3] = in_item.prefix_bits[1];
        dec_next.pre_byte[3] = xibe_pkg::BYTE_ADSIZE;
        dec_next.pre_mask[4] = in_item.prefix_bits[2];
        dec_next.pre_byte[4] = xibe_pkg::BYTE_REX | {4'b0000, w, r, x, b};

        // VEX bits go out as supplied, no inversion
        dec_next.vex_long = !vex_short;
        if (vex_short)
        begin
            dec_next.vex_byte[0] = xibe_pkg::BYTE_VEX2;
            dec_next.vex_byte[1] = {r, vvvv, l, pp};
        end
        else
        begin
            dec_next.vex_byte[0] = xibe_pkg::BYTE_VEX3;
            dec_next.vex_byte[1] = {r, x, b, map};
        end
        dec_next.vex_byte[2] = {w, vvvv, l, pp};

        // opcode goes out most significant byte first
        dec_next.op_byte[0] = in_item.opcode[23:16];
        dec_next.op_byte[1] = in_item.opcode[15:8];
        dec_next.op_byte[2] = in_item.opcode[7:0];
        dec_next.op_mask[0] = in_item.opcode_length == 2'd3;
        dec_next.op_mask[1] = in_item.opcode_length[1];
        dec_next.op_mask[2] = in_item.opcode_length != 2'd0;

        // SIB only follows a present ModRM
        dec_next.ms_byte[0] = in_item.modrm_sib[7:0];
        dec_next.ms_byte[1] = in_item.modrm_sib[15:8];
        dec_next.ms_mask[0] = in_item.modrm_sib[16];
        dec_next.ms_mask[1] = in_item.modrm_sib[16] && in_item.modrm_sib[17];

        dec_next.disp      = in_item.displacement;
        dec_next.disp_mask = xibe_pkg::size_mask(in_item.arg_sizes[2:0]);
        dec_next.imm       = in_item.immediate;
        dec_next.imm_mask  = xibe_pkg::size_mask(in_item.arg_sizes[5:3]);
        dec_next.nop_len   = in_item.nop_length;

        valid_next = in_stall ? valid_reg : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec_valid = valid_reg;
    assign dec       = dec_reg;

endmodule

`default_nettype wire

// ===== rtl/core/xibe_assemble.sv =====
// ----------------------------------------------------------------------------
// x86 instruction byte encoder: assemble stage
// Place the decoded bytes into emit-order slots per instruction kind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xibe_assemble (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            dec_valid,
    input  wire xibe_pkg::dec_t  dec,
    output logic                 dec_stall,
    output logic                 slot_valid,
    output xibe_pkg::slot_t      slot,
    input  wire logic            slot_stall
);

    logic            valid_reg;
    logic            valid_next;
    xibe_pkg::slot_t slot_reg;
    xibe_pkg::slot_t slot_next;

    assign dec_stall = valid_reg && slot_stall;

    always_comb
    begin
        slot_next.mask  = '0;
        slot_next.bytes = '0;

        // opcode, ModRM/SIB and argument slots as laid out for legacy and VEX
        for (int i = 0; i < 3; i++)
        begin
            slot_next.bytes[xibe_pkg::SLOT_OP + i] = dec.op_byte[i];
        end
        for (int i = 0; i < 2; i++)
        begin
            slot_next.bytes[xibe_pkg::SLOT_MS + i] = dec.ms_byte[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            slot_next.bytes[xibe_pkg::SLOT_DISP + i] = dec.disp[8*i +: 8];
            slot_next.bytes[xibe_pkg::SLOT_IMM + i]  = dec.imm[8*i +: 8];
        end

        case (dec.kind)
            xibe_pkg::KIND_LEGACY:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    slot_next.bytes[xibe_pkg::SLOT_PRE + i] = dec.pre_byte[i];
                    slot_next.mask[xibe_pkg::SLOT_PRE + i]  = dec.pre_mask[i];
                end
                slot_next.mask[xibe_pkg::SLOT_OP +: 3]   = dec.op_mask;
                slot_next.mask[xibe_pkg::SLOT_MS +: 2]   = dec.ms_mask;
                slot_next.mask[xibe_pkg::SLOT_DISP +: 8] = dec.disp_mask;
                slot_next.mask[xibe_pkg::SLOT_IMM +: 8]  = dec.imm_mask;
            end
            xibe_pkg::KIND_VEX:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    slot_next.bytes[xibe_pkg::SLOT_PRE + i] = dec.vex_byte[i];
                end
                slot_next.mask[xibe_pkg::SLOT_PRE +: 3]  = {dec.vex_long, 2'b11};
                slot_next.mask[xibe_pkg::SLOT_OP +: 3]   = dec.op_mask;
                slot_next.mask[xibe_pkg::SLOT_MS +: 2]   = dec.ms_mask;
                slot_next.mask[xibe_pkg::SLOT_DISP +: 8] = dec.disp_mask;
                slot_next.mask[xibe_pkg::SLOT_IMM +: 8]  = dec.imm_mask;
            end
            xibe_pkg::KIND_3DNOW:
            begin
                // opcode trails as suffix, in the immediate slots
                slot_next.bytes[xibe_pkg::SLOT_PRE]     = xibe_pkg::BYTE_ESC;
                slot_next.bytes[xibe_pkg::SLOT_PRE + 1] = xibe_pkg::BYTE_ESC;
                slot_next.mask[xibe_pkg::SLOT_PRE +: 2] = 2'b11;
                for (int i = 0; i < 3; i++)
                begin
                    slot_next.bytes[xibe_pkg::SLOT_IMM + i] = dec.op_byte[i];
                end
                slot_next.mask[xibe_pkg::SLOT_MS +: 2]   = dec.ms_mask;
                slot_next.mask[xibe_pkg::SLOT_DISP +: 8] = dec.disp_mask;
                slot_next.mask[xibe_pkg::SLOT_IMM +: 3]  = dec.op_mask;
            end
            xibe_pkg::KIND_NOP:
            begin
                // length minus one 66 bytes, then the opcode
                for (int i = 0; i < xibe_pkg::NOP_MAX; i++)
                begin
                    slot_next.bytes[i] = xibe_pkg::BYTE_OPSIZE;
                    slot_next.mask[i]  = dec.nop_len > 4'(i + 1);
                end
                for (int i = 0; i < 3; i++)
                begin
                    slot_next.bytes[xibe_pkg::SLOT_IMM + i] = dec.op_byte[i];
                end
                slot_next.mask[xibe_pkg::SLOT_IMM +: 3] = dec.op_mask;
            end
            default:
            begin
                slot_next.mask = '0;
            end
        endcase

        // drop items that produce no bytes
        valid_next = dec_stall ? valid_reg : (dec_valid && (slot_next.mask != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!dec_stall && dec_valid)
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot_valid = valid_reg;
    assign slot       = slot_reg;

endmodule

`default_nettype wire

// ===== rtl/core/xibe_serial.sv =====
// ----------------------------------------------------------------------------
// x86 instruction byte encoder: serializer
// Emit the lowest present slot each cycle into the output register, unless the output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xibe_serial (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            slot_valid,
    input  wire xibe_pkg::slot_t slot,
    output logic                 slot_stall,
    output logic                 out_valid,
    output logic [7:0]           out_byte,
    output logic                 last,
    input  wire logic            out_stall
);

    logic [xibe_pkg::NUM_SLOTS-1:0]      mask_reg;
    logic [xibe_pkg::NUM_SLOTS-1:0]      mask_next;
    logic [xibe_pkg::NUM_SLOTS-1:0][7:0] bytes_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [7:0]                          out_byte_reg;
    logic                                last_reg;

    logic                           out_load;
    logic                           emit;
    logic                           take;
    logic [xibe_pkg::NUM_SLOTS-1:0] low;
    logic [xibe_pkg::NUM_SLOTS-1:0] rest;
    logic [7:0]                     sel_byte;

    always_comb
    begin
        out_load = !out_valid_reg || !out_stall;
        emit     = out_load && (mask_reg != '0);
        low      = mask_reg & (~mask_reg + {{(xibe_pkg::NUM_SLOTS-1){1'b0}}, 1'b1});
        rest     = mask_reg & ~low;

        sel_byte = 8'h00;
        for (int i = 0; i < xibe_pkg::NUM_SLOTS; i++)
        begin
            sel_byte = sel_byte | (bytes_reg[i] & {8{low[i]}});
        end

        // take the next item once the current one runs out
        slot_stall = !((mask_reg == '0) || (emit && (rest == '0)));
        take       = slot_valid && !slot_stall;

        if (take)
        begin
            mask_next = slot.mask;
        end
        else if (emit)
        begin
            mask_next = rest;
        end
        else
        begin
            mask_next = mask_reg;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            bytes_reg <= slot.bytes;
        end
        if (emit)
        begin
            out_byte_reg <= sel_byte;
            last_reg     <= rest == '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/x86_instruction_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// x86 instruction byte encoder
// Path: the decode, assemble and serializer registers lead to the output register.
// Throughput: one byte per cycle while out_stall is low; the next item loads as
// the last byte leaves; items without bytes are dropped. The serializer sets the rate.
// Reset: asynchronous, active low; clears all valid bits and pending bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module x86_instruction_byte_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // instruction channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [1:0]  lock_rep,
    input  wire logic [2:0]  segment,
    input  wire logic [6:0]  prefix_bits,
    input  wire logic [12:0] vex_fields,
    input  wire logic [23:0] opcode,
    input  wire logic [1:0]  opcode_length,
    input  wire logic [17:0] modrm_sib,
    input  wire logic [63:0] displacement,
    input  wire logic [63:0] immediate,
    input  wire logic [5:0]  arg_sizes,
    input  wire logic [3:0]  nop_length,

    // byte channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last
);

    xibe_pkg::item_t in_item;
    xibe_pkg::dec_t  dec;
    xibe_pkg::slot_t slot;
    logic            dec_valid;
    logic            dec_stall;
    logic            slot_valid;
    logic            slot_stall;

    // Bundle the instruction fields for the decode stage.
    always_comb
    begin
        in_item.kind          = kind;
        in_item.lock_rep      = lock_rep;
        in_item.segment       = segment;
        in_item.prefix_bits   = prefix_bits;
        in_item.vex_fields    = vex_fields;
        in_item.opcode        = opcode;
        in_item.opcode_length = opcode_length;
        in_item.modrm_sib     = modrm_sib;
        in_item.displacement  = displacement;
        in_item.immediate     = immediate;
        in_item.arg_sizes     = arg_sizes;
        in_item.nop_length    = nop_length;
    end

    // Stage 1: turn fields into candidate bytes, each with a present bit.
    xibe_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .in_stall  (in_stall),
        .dec_valid (dec_valid),
        .dec       (dec),
        .dec_stall (dec_stall)
    );

    // Stage 2: lay the bytes out in emit order for the instruction kind;
    // drop items with no bytes here so they never reach the serializer.
    xibe_assemble u_assemble (
        .clk        (clk),
        .rst_n      (rst_n),
        .dec_valid  (dec_valid),
        .dec        (dec),
        .dec_stall  (dec_stall),
        .slot_valid (slot_valid),
        .slot       (slot),
        .slot_stall (slot_stall)
    );

    // Stage 3: walk the present slots lowest first, one byte per unstalled cycle,
    // into a registered output; the next item loads as the last byte leaves.
    xibe_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_valid (slot_valid),
        .slot       (slot),
        .slot_stall (slot_stall),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .last       (last),
        .out_stall  (out_stall)
    );

endmodule

`default_nettype wire
